// File: rtl/vgsg_pkg.sv
// ----------------------------------------------------------------------------
// vgsg_pkg: shared types, stroke program and arithmetic helpers
// Holds the stroke program of every glyph, the reciprocal table used for the
// interpolation divide and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package vgsg_pkg;

    localparam int CoordW    = 16;
    localparam int ProgDepth = 67;
    localparam int IdxW      = 7;
    localparam int MaxWords  = 60;
    localparam int RecipW    = 24;
    localparam int RecipShift = 23;

    localparam logic [2:0] GLYPH_A       = 3'd0;
    localparam logic [2:0] GLYPH_B       = 3'd1;
    localparam logic [2:0] GLYPH_C       = 3'd2;
    localparam logic [2:0] GLYPH_D       = 3'd3;
    localparam logic [2:0] GLYPH_E       = 3'd4;
    localparam logic [2:0] GLYPH_CIRCLE  = 3'd5;
    localparam logic [2:0] GLYPH_CROSS   = 3'd6;
    localparam logic [2:0] GLYPH_UNKNOWN = 3'd7;

    localparam logic [1:0] REG_ORIGIN_X     = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y     = 2'd1;
    localparam logic [1:0] REG_GLYPH_SIZE   = 2'd2;
    localparam logic [1:0] REG_INTERP_STEPS = 2'd3;

    localparam logic K_POINT = 1'b0;
    localparam logic K_SEG   = 1'b1;

    // One entry of the stroke program.
    typedef struct packed {
        logic       kind;
        logic       pen;
        logic       start;
        logic       last;
        logic [8:0] vx;
        logic [8:0] vy;
    } op_t;

    typedef struct packed {
        logic start;
        logic scale;
        logic mul1;
        logic mul2;
        logic emit_pt;
        logic emit_seg;
    } cmd_t;

    typedef struct packed {
        logic accept;
        logic code_empty;
        logic is_seg;
        logic step_done;
        logic pt_final;
        logic seg_final;
        logic out_free;
    } stat_t;

    function automatic op_t mk(input logic kind, input logic pen, input logic start,
                               input logic last, input logic [8:0] vx,
                               input logic [8:0] vy);
        op_t o;
        o.kind  = kind;
        o.pen   = pen;
        o.start = start;
        o.last  = last;
        o.vx    = vx;
        o.vy    = vy;
        return o;
    endfunction

    function automatic op_t pt(input logic [8:0] vx, input logic [8:0] vy);
        return mk(K_POINT, 1'b1, 1'b1, 1'b0, vx, vy);
    endfunction

    function automatic op_t sg(input logic [8:0] vx, input logic [8:0] vy,
                               input logic last);
        return mk(K_SEG, 1'b1, 1'b0, last, vx, vy);
    endfunction

    function automatic op_t mf(input logic [8:0] vx, input logic [8:0] vy);
        return mk(K_POINT, 1'b0, 1'b1, 1'b0, vx, vy);
    endfunction

    function automatic op_t mt(input logic [8:0] vx, input logic [8:0] vy);
        return mk(K_POINT, 1'b0, 1'b0, 1'b0, vx, vy);
    endfunction

    function automatic op_t cp(input logic [8:0] vx, input logic [8:0] vy,
                               input logic start, input logic last);
        return mk(K_POINT, 1'b1, start, last, vx, vy);
    endfunction

    // First program entry of each glyph.
    function automatic logic [IdxW-1:0] glyph_base(input logic [2:0] code);
        logic [IdxW-1:0] b;
        case (code)
            GLYPH_A:      b = 7'd0;
            GLYPH_B:      b = 7'd7;
            GLYPH_C:      b = 7'd18;
            GLYPH_D:      b = 7'd22;
            GLYPH_E:      b = 7'd28;
            GLYPH_CIRCLE: b = 7'd36;
            GLYPH_CROSS:  b = 7'd61;
            default:      b = 7'd0;
        endcase
        return b;
    endfunction

    // Stroke program: vertices in Q8 of the unit square.
    function automatic op_t op_rom(input logic [IdxW-1:0] idx);
        op_t o;
        case (idx)
            // A
            7'd0:  o = pt(9'd0, 9'd0);
            7'd1:  o = sg(9'd128, 9'd256, 1'b0);
            7'd2:  o = sg(9'd256, 9'd0, 1'b0);
            7'd3:  o = mf(9'd256, 9'd0);
            7'd4:  o = mt(9'd64, 9'd128);
            7'd5:  o = pt(9'd64, 9'd128);
            7'd6:  o = sg(9'd192, 9'd128, 1'b1);
            // B
            7'd7:  o = pt(9'd0, 9'd0);
            7'd8:  o = sg(9'd0, 9'd256, 1'b0);
            7'd9:  o = sg(9'd205, 9'd256, 1'b0);
            7'd10: o = sg(9'd205, 9'd128, 1'b0);
            7'd11: o = sg(9'd0, 9'd128, 1'b0);
            7'd12: o = mf(9'd0, 9'd128);
            7'd13: o = mt(9'd0, 9'd128);
            7'd14: o = pt(9'd0, 9'd128);
            7'd15: o = sg(9'd256, 9'd128, 1'b0);
            7'd16: o = sg(9'd256, 9'd0, 1'b0);
            7'd17: o = sg(9'd0, 9'd0, 1'b1);
            // C
            7'd18: o = pt(9'd256, 9'd256);
            7'd19: o = sg(9'd0, 9'd256, 1'b0);
            7'd20: o = sg(9'd0, 9'd0, 1'b0);
            7'd21: o = sg(9'd256, 9'd0, 1'b1);
            // D
            7'd22: o = pt(9'd0, 9'd0);
            7'd23: o = sg(9'd0, 9'd256, 1'b0);
            7'd24: o = sg(9'd179, 9'd256, 1'b0);
            7'd25: o = sg(9'd256, 9'd128, 1'b0);
            7'd26: o = sg(9'd179, 9'd0, 1'b0);
            7'd27: o = sg(9'd0, 9'd0, 1'b1);
            // E
            7'd28: o = pt(9'd256, 9'd256);
            7'd29: o = sg(9'd0, 9'd256, 1'b0);
            7'd30: o = sg(9'd0, 9'd0, 1'b0);
            7'd31: o = sg(9'd256, 9'd0, 1'b0);
            7'd32: o = mf(9'd256, 9'd0);
            7'd33: o = mt(9'd0, 9'd128);
            7'd34: o = pt(9'd0, 9'd128);
            7'd35: o = sg(9'd192, 9'd128, 1'b1);
            // Circle: 128 plus the rounded Q7 cosine and sine, every 15 degrees.
            7'd36: o = cp(9'd256, 9'd128, 1'b1, 1'b0);
            7'd37: o = cp(9'd252, 9'd161, 1'b0, 1'b0);
            7'd38: o = cp(9'd239, 9'd192, 1'b0, 1'b0);
            7'd39: o = cp(9'd219, 9'd219, 1'b0, 1'b0);
            7'd40: o = cp(9'd192, 9'd239, 1'b0, 1'b0);
            7'd41: o = cp(9'd161, 9'd252, 1'b0, 1'b0);
            7'd42: o = cp(9'd128, 9'd256, 1'b0, 1'b0);
            7'd43: o = cp(9'd95, 9'd252, 1'b0, 1'b0);
            7'd44: o = cp(9'd64, 9'd239, 1'b0, 1'b0);
            7'd45: o = cp(9'd37, 9'd219, 1'b0, 1'b0);
            7'd46: o = cp(9'd17, 9'd192, 1'b0, 1'b0);
            7'd47: o = cp(9'd4, 9'd161, 1'b0, 1'b0);
            7'd48: o = cp(9'd0, 9'd128, 1'b0, 1'b0);
            7'd49: o = cp(9'd4, 9'd95, 1'b0, 1'b0);
            7'd50: o = cp(9'd17, 9'd64, 1'b0, 1'b0);
            7'd51: o = cp(9'd37, 9'd37, 1'b0, 1'b0);
            7'd52: o = cp(9'd64, 9'd17, 1'b0, 1'b0);
            7'd53: o = cp(9'd95, 9'd4, 1'b0, 1'b0);
            7'd54: o = cp(9'd128, 9'd0, 1'b0, 1'b0);
            7'd55: o = cp(9'd161, 9'd4, 1'b0, 1'b0);
            7'd56: o = cp(9'd192, 9'd17, 1'b0, 1'b0);
            7'd57: o = cp(9'd219, 9'd37, 1'b0, 1'b0);
            7'd58: o = cp(9'd239, 9'd64, 1'b0, 1'b0);
            7'd59: o = cp(9'd252, 9'd95, 1'b0, 1'b0);
            7'd60: o = cp(9'd256, 9'd128, 1'b0, 1'b1);
            // Cross
            7'd61: o = pt(9'd0, 9'd256);
            7'd62: o = sg(9'd256, 9'd0, 1'b0);
            7'd63: o = mf(9'd256, 9'd0);
            7'd64: o = mt(9'd0, 9'd0);
            7'd65: o = pt(9'd0, 9'd0);
            7'd66: o = sg(9'd256, 9'd256, 1'b1);
            default: o = mk(K_POINT, 1'b0, 1'b0, 1'b1, 9'd0, 9'd0);
        endcase
        return o;
    endfunction

    // ceil(2^23 / n) for n = 1..8, exact for dividends below 2^19.
    function automatic logic [RecipW-1:0] recip(input logic [3:0] n);
        logic [RecipW-1:0] r;
        case (n)
            4'd1:    r = 24'd8388608;
            4'd2:    r = 24'd4194304;
            4'd3:    r = 24'd2796203;
            4'd4:    r = 24'd2097152;
            4'd5:    r = 24'd1677722;
            4'd6:    r = 24'd1398102;
            4'd7:    r = 24'd1198373;
            default: r = 24'd1048576;
        endcase
        return r;
    endfunction

    // Clamp a 20-bit signed value to the signed coordinate range.
    function automatic logic [CoordW-1:0] sat(input logic signed [19:0] v);
        logic [CoordW-1:0] r;
        if (v > 20'sd32767)
            r = 16'h7FFF;
        else if (v < -20'sd32768)
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

// File: rtl/vgsg_if.sv
// ----------------------------------------------------------------------------
// vgsg_if: valid/ready channels of the glyph stroke generator
// The glyph code channel and the point channel, each with source and sink.
// ----------------------------------------------------------------------------
interface vgsg_glyph_if;
    logic       valid;
    logic       ready;
    logic [2:0] glyph_code;

    modport source (output valid, output glyph_code, input ready);
    modport sink (input valid, input glyph_code, output ready);
endinterface

interface vgsg_point_if;
    logic        valid;
    logic        ready;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        pen_down;
    logic        stroke_start;
    logic        last_point;

    modport source (output valid, output point_x, output point_y, output pen_down,
                    output stroke_start, output last_point, input ready);
    modport sink (input valid, input point_x, input point_y, input pen_down,
                  input stroke_start, input last_point, output ready);
endinterface

// File: rtl/vgsg_ctrl.sv
// ----------------------------------------------------------------------------
// vgsg_ctrl: sequencing state machine
// Walks the stroke program one entry at a time and issues datapath commands.
// ----------------------------------------------------------------------------
module vgsg_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  vgsg_pkg::stat_t stat,
    output vgsg_pkg::cmd_t  cmd,
    output logic            in_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_POINT,
        S_MUL1,
        S_MUL2,
        S_SEG
    } state_t;

    state_t state_reg, state_next;

    // Commands follow the state; emits wait for a free output register.
    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        cmd.start    = (state_reg == S_IDLE) && stat.accept;
        cmd.scale    = (state_reg == S_SCALE);
        cmd.mul1     = (state_reg == S_MUL1);
        cmd.mul2     = (state_reg == S_MUL2);
        cmd.emit_pt  = (state_reg == S_POINT) && stat.out_free;
        cmd.emit_seg = (state_reg == S_SEG) && stat.out_free;
        case (state_reg)
            S_IDLE:
            begin
                if (stat.accept && !stat.code_empty)
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                state_next = stat.is_seg ? S_MUL1 : S_POINT;
            end
            S_POINT:
            begin
                if (stat.out_free)
                    state_next = stat.pt_final ? S_IDLE : S_SCALE;
            end
            S_MUL1:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                state_next = S_SEG;
            end
            S_SEG:
            begin
                if (stat.out_free)
                begin
                    if (stat.seg_final)
                        state_next = S_IDLE;
                    else if (stat.step_done)
                        state_next = S_SCALE;
                    else
                        state_next = S_MUL1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// File: rtl/vgsg_datapath.sv
// ----------------------------------------------------------------------------
// vgsg_datapath: configuration, vertex scaling and interpolation
// Holds the registers, scales program vertices, interpolates segments with a
// reciprocal multiply and drives the output word register.
// ----------------------------------------------------------------------------
module vgsg_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [2:0]        in_code,
    input  vgsg_pkg::cmd_t    cmd,
    output vgsg_pkg::stat_t   stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       out_x,
    output logic [15:0]       out_y,
    output logic              out_pen,
    output logic              out_start,
    output logic              out_last
);

    logic [15:0] org_x_reg, org_y_reg;
    logic [14:0] size_reg;
    logic [3:0]  steps_reg;

    logic [vgsg_pkg::IdxW-1:0] idx_reg;
    logic [3:0]  n_reg, step_reg, n_next;
    logic [5:0]  count_reg;
    logic signed [17:0] ps_x_reg, ps_y_reg, e_x_reg, e_y_reg;
    logic [19:0] dm_x_reg, dm_y_reg;
    logic        neg_x_reg, neg_y_reg;
    logic [18:0] q_x_reg, q_y_reg;
    logic        out_valid_reg;

    vgsg_pkg::op_t op;
    logic        cap_hit;
    logic [23:0] px, py;
    logic [15:0] sx, sy;
    logic signed [17:0] e_x_next, e_y_next;
    logic signed [21:0] diff_x, diff_y, d_x, d_y;
    logic [20:0] mag_x, mag_y;
    logic [43:0] prod_x, prod_y;
    logic signed [19:0] v_x, v_y;

    assign op      = vgsg_pkg::op_rom(idx_reg);
    assign cap_hit = (count_reg == 6'(vgsg_pkg::MaxWords - 1));

    // Effective step count: zero acts as one, above eight acts as eight.
    always_comb
    begin
        if (steps_reg == 4'd0)
            n_next = 4'd1;
        else if (steps_reg > 4'd8)
            n_next = 4'd8;
        else
            n_next = steps_reg;
    end

    // Vertex scaling with round half up, then origin offset.
    always_comb
    begin
        px       = 24'(op.vx) * 24'(size_reg);
        py       = 24'(op.vy) * 24'(size_reg);
        sx       = 16'((px + 24'd128) >> 8);
        sy       = 16'((py + 24'd128) >> 8);
        e_x_next = $signed({{2{org_x_reg[15]}}, org_x_reg}) + $signed({2'b00, sx});
        e_y_next = $signed({{2{org_y_reg[15]}}, org_y_reg}) + $signed({2'b00, sy});
    end

    // Segment offset times step index, as magnitude and sign.
    always_comb
    begin
        diff_x = 22'(e_x_reg) - 22'(ps_x_reg);
        diff_y = 22'(e_y_reg) - 22'(ps_y_reg);
        d_x    = diff_x * $signed({18'd0, step_reg});
        d_y    = diff_y * $signed({18'd0, step_reg});
        mag_x  = d_x[21] ? 21'(-d_x) : 21'(d_x);
        mag_y  = d_y[21] ? 21'(-d_y) : 21'(d_y);
    end

    // Rounded quotient by reciprocal multiply.
    always_comb
    begin
        prod_x = 44'(dm_x_reg) * 44'(vgsg_pkg::recip(n_reg));
        prod_y = 44'(dm_y_reg) * 44'(vgsg_pkg::recip(n_reg));
    end

    // Interpolated point, halves away from zero.
    always_comb
    begin
        v_x = neg_x_reg ? 20'(ps_x_reg) - $signed({1'b0, q_x_reg})
                        : 20'(ps_x_reg) + $signed({1'b0, q_x_reg});
        v_y = neg_y_reg ? 20'(ps_y_reg) - $signed({1'b0, q_y_reg})
                        : 20'(ps_y_reg) + $signed({1'b0, q_y_reg});
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg <= 16'd0;
            org_y_reg <= 16'd0;
            size_reg  <= 15'd256;
            steps_reg <= 4'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vgsg_pkg::REG_ORIGIN_X:     org_x_reg <= cfg_data;
                vgsg_pkg::REG_ORIGIN_Y:     org_y_reg <= cfg_data;
                vgsg_pkg::REG_GLYPH_SIZE:   size_reg  <= cfg_data[14:0];
                vgsg_pkg::REG_INTERP_STEPS: steps_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Sequencing control: program index, step and word counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            n_reg     <= 4'd1;
            step_reg  <= 4'd1;
            count_reg <= 6'd0;
        end
        else
        begin
            if (cmd.start)
            begin
                idx_reg   <= vgsg_pkg::glyph_base(in_code);
                n_reg     <= n_next;
                count_reg <= 6'd0;
            end
            if (cmd.scale)
                step_reg <= 4'd1;
            if (cmd.emit_pt)
            begin
                idx_reg   <= idx_reg + 1'b1;
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.emit_seg)
            begin
                count_reg <= count_reg + 1'b1;
                if (step_reg == n_reg)
                    idx_reg <= idx_reg + 1'b1;
                else
                    step_reg <= step_reg + 1'b1;
            end
        end
    end

    // Arithmetic pipeline registers.
    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            e_x_reg <= e_x_next;
            e_y_reg <= e_y_next;
        end
        if (cmd.emit_pt || (cmd.emit_seg && step_reg == n_reg))
        begin
            ps_x_reg <= e_x_reg;
            ps_y_reg <= e_y_reg;
        end
        if (cmd.mul1)
        begin
            dm_x_reg  <= 20'(mag_x) + 20'(n_reg >> 1);
            dm_y_reg  <= 20'(mag_y) + 20'(n_reg >> 1);
            neg_x_reg <= d_x[21];
            neg_y_reg <= d_y[21];
        end
        if (cmd.mul2)
        begin
            q_x_reg <= prod_x[vgsg_pkg::RecipShift+18:vgsg_pkg::RecipShift];
            q_y_reg <= prod_y[vgsg_pkg::RecipShift+18:vgsg_pkg::RecipShift];
        end
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_pt || cmd.emit_seg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_pt)
        begin
            out_x     <= vgsg_pkg::sat(20'(e_x_reg));
            out_y     <= vgsg_pkg::sat(20'(e_y_reg));
            out_pen   <= op.pen;
            out_start <= op.start;
            out_last  <= op.last || cap_hit;
        end
        else if (cmd.emit_seg)
        begin
            out_x     <= vgsg_pkg::sat(v_x);
            out_y     <= vgsg_pkg::sat(v_y);
            out_pen   <= 1'b1;
            out_start <= 1'b0;
            out_last  <= (op.last && step_reg == n_reg) || cap_hit;
        end
    end

    assign out_valid = out_valid_reg;

    // Status towards the controller.
    always_comb
    begin
        stat.accept     = in_valid && in_ready;
        stat.code_empty = (in_code == vgsg_pkg::GLYPH_UNKNOWN);
        stat.is_seg     = (op.kind == vgsg_pkg::K_SEG);
        stat.step_done  = (step_reg == n_reg);
        stat.pt_final   = op.last || cap_hit;
        stat.seg_final  = (op.last && step_reg == n_reg) || cap_hit;
        stat.out_free   = !out_valid_reg || out_ready;
    end

endmodule

// File: rtl/vector_glyph_stroke_generator.sv
// ----------------------------------------------------------------------------
// vector_glyph_stroke_generator: pen-plotter point lists for glyph codes
// A glyph code in, a sequence of saturated Q12.4 points out.
// ----------------------------------------------------------------------------
// The first word is loaded in the point state that follows the scale state once
// the glyph code is accepted. Each vertex or move point passes through a scale
// state and a point state; each segment scales its end vertex once and then takes
// every interpolated point through the two multiply states and the segment state.
// Output stalls hold the sequence; a new code is taken once the last word is loaded.
// Unknown codes are taken without output. Reset clears the control state and restores the defaults.
module vector_glyph_stroke_generator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    vgsg_glyph_if.sink    glyph_in,
    vgsg_point_if.source  point_out
);

    vgsg_pkg::cmd_t  cmd;
    vgsg_pkg::stat_t stat;
    logic            in_ready;

    assign glyph_in.ready = in_ready;

    // Sequencer.
    vgsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    // Arithmetic and output word.
    vgsg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (glyph_in.valid),
        .in_ready  (in_ready),
        .in_code   (glyph_in.glyph_code),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (point_out.valid),
        .out_ready (point_out.ready),
        .out_x     (point_out.point_x),
        .out_y     (point_out.point_y),
        .out_pen   (point_out.pen_down),
        .out_start (point_out.stroke_start),
        .out_last  (point_out.last_point)
    );

endmodule

// File: rtl/vgsg_checker.sv
// ----------------------------------------------------------------------------
// vgsg_checker: port-level checks of the glyph stroke generator
// Watches the handshakes and the glyph framing seen on the top-level ports.
// ----------------------------------------------------------------------------
module vgsg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [2:0]  in_code,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_x,
    input logic        out_last
);

    // A stalled word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_last))
        else $error("stalled output word changed");

    // A known glyph code keeps the block busy in the next cycle.
    a_busy_after_code: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_code != vgsg_pkg::GLYPH_UNKNOWN |=> !in_ready)
        else $error("input taken again straight after a glyph code");

    // No new code is taken while a glyph is still part-way through.
    a_no_code_mid_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |-> !in_ready)
        else $error("input ready before the last word of a glyph");

endmodule

bind vector_glyph_stroke_generator vgsg_checker u_vgsg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (glyph_in.valid),
    .in_ready  (glyph_in.ready),
    .in_code   (glyph_in.glyph_code),
    .out_valid (point_out.valid),
    .out_ready (point_out.ready),
    .out_x     (point_out.point_x),
    .out_last  (point_out.last_point)
);
